// File: sv/utf8_wide_glyph_classifier_top_assert.svh
// Assertion macros for the UTF-8 wide glyph classifier.
// Used by utf8_wide_glyph_classifier_top; expects clk and arst_n in scope.
`ifndef UTF8_WIDE_GLYPH_CLASSIFIER_TOP_ASSERT_SVH
`define UTF8_WIDE_GLYPH_CLASSIFIER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define UWGC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define UWGC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define UWGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/uwgc_pkg.sv
// Package for the UTF-8 wide glyph classifier: payload types, verdict codes
// and the code point bounds. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uwgc_pkg;

	localparam int CP_W = 21;

	typedef logic [CP_W-1:0] code_point_t;

	typedef enum logic [1:0] {
		VERDICT_UNDECIDED = 2'd0,
		VERDICT_TRUE      = 2'd1,
		VERDICT_FALSE     = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic is_wide;
		logic is_emoji;
	} result_item_t;

	localparam code_point_t CP_VS16      = 21'h00FE0F;
	localparam code_point_t CP_EMOJI_LO  = 21'h01F300;
	localparam code_point_t CP_CJK_LO    = 21'h002E80;
	localparam code_point_t CP_CJK_HI    = 21'h009FFF;
	localparam code_point_t CP_HANGUL_LO = 21'h00AC00;
	localparam code_point_t CP_HANGUL_HI = 21'h00D7A3;
	localparam code_point_t CP_FULL_LO   = 21'h00FF00;
	localparam code_point_t CP_FULL_HI   = 21'h00FF60;

endpackage

`default_nettype wire

// File: sv/utf8_wide_glyph_classifier_top.sv
// UTF-8 wide glyph classifier: top level with decode state and result register.
// Depends on uwgc_pkg and utf8_wide_glyph_classifier_top_assert.svh.
//
// Usage:
// Bytes of one glyph string arrive on the byte channel (byte_valid,
// byte_ready, byte_item), one byte per transfer, with final_byte set on the
// last byte. Each final byte produces one result transfer on the result
// channel (result_valid, result_ready, result_item) carrying is_wide and
// is_emoji; other bytes produce nothing.
// Path: a byte in the input stage is decoded combinationally; a final
// byte's result is registered as the byte leaves the input stage, and
// result_valid stays high until that result transfers.
// Throughput: one byte per cycle while no final byte waits on a held
// result, set by the single decode stage between the input register and
// the result register.
// Stalls: while a result waits, non-final bytes keep flowing; a final byte
// holds in the input stage, with byte_ready low, until the result register
// frees.
// Reset: arst_n clears the input stage, the result register's valid flag,
// the pending count, the accumulator and both verdicts to undecided.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_wide_glyph_classifier_top_assert.svh"

module utf8_wide_glyph_classifier_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  byte_valid,
	output logic                       byte_ready,
	input  wire uwgc_pkg::byte_item_t  byte_item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output uwgc_pkg::result_item_t     result_item
);

	logic                  byte_valid_s1;
	uwgc_pkg::byte_item_t  item_s1;

	logic [1:0]            pend_q;
	uwgc_pkg::code_point_t acc_q;
	uwgc_pkg::verdict_t    wide_q;
	uwgc_pkg::verdict_t    emoji_q;

	logic                  result_valid_q;
	uwgc_pkg::result_item_t result_q;

	logic                  adv_s1;
	logic [1:0]            pend_n;
	uwgc_pkg::code_point_t acc_n;
	uwgc_pkg::verdict_t    wide_n;
	uwgc_pkg::verdict_t    emoji_n;
	uwgc_pkg::result_item_t result_n;
	logic                  cp_done;
	logic                  seq_error;
	logic                  cp_emoji;
	logic                  cp_wide;
	logic [7:0]            b;

	// A final byte needs the result register; other bytes always move on.
	assign adv_s1 = byte_valid_s1 &&
		(!item_s1.final_byte || !result_valid_q || result_ready);
	assign byte_ready   = !byte_valid_s1 || adv_s1;
	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	always_comb begin
		b         = item_s1.text_byte;
		pend_n    = pend_q;
		acc_n     = acc_q;
		wide_n    = wide_q;
		emoji_n   = emoji_q;
		cp_done   = 1'b0;
		seq_error = 1'b0;

		// Once both verdicts are settled, the rest of the string is ignored.
		if (wide_q == uwgc_pkg::VERDICT_UNDECIDED ||
			emoji_q == uwgc_pkg::VERDICT_UNDECIDED) begin
			if (pend_q != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					seq_error = 1'b1;
				end else begin
					acc_n   = {acc_q[uwgc_pkg::CP_W-7:0], b[5:0]};
					pend_n  = pend_q - 2'd1;
					cp_done = (pend_q == 2'd1);
				end
			end else if (b[7]) begin
				if (b[7:5] == 3'b110) begin
					acc_n  = {16'd0, b[4:0]};
					pend_n = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					acc_n  = {17'd0, b[3:0]};
					pend_n = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					acc_n  = {18'd0, b[2:0]};
					pend_n = 2'd3;
				end else begin
					seq_error = 1'b1;
				end
			end
		end

		cp_emoji = (acc_n == uwgc_pkg::CP_VS16) || (acc_n >= uwgc_pkg::CP_EMOJI_LO);
		cp_wide  = cp_emoji
			|| (acc_n >= uwgc_pkg::CP_CJK_LO && acc_n <= uwgc_pkg::CP_CJK_HI)
			|| (acc_n >= uwgc_pkg::CP_HANGUL_LO && acc_n <= uwgc_pkg::CP_HANGUL_HI)
			|| (acc_n >= uwgc_pkg::CP_FULL_LO && acc_n <= uwgc_pkg::CP_FULL_HI);

		if (cp_done) begin
			if (cp_emoji && emoji_n == uwgc_pkg::VERDICT_UNDECIDED) begin
				emoji_n = uwgc_pkg::VERDICT_TRUE;
			end
			if (cp_wide && wide_n == uwgc_pkg::VERDICT_UNDECIDED) begin
				wide_n = uwgc_pkg::VERDICT_TRUE;
			end
		end

		// A malformed byte, or a string that ends mid-sequence, settles
		// every open verdict as false.
		if (seq_error || (item_s1.final_byte && pend_n != 2'd0)) begin
			if (wide_n == uwgc_pkg::VERDICT_UNDECIDED) begin
				wide_n = uwgc_pkg::VERDICT_FALSE;
			end
			if (emoji_n == uwgc_pkg::VERDICT_UNDECIDED) begin
				emoji_n = uwgc_pkg::VERDICT_FALSE;
			end
			pend_n = 2'd0;
			acc_n  = '0;
		end

		result_n.is_wide  = (wide_n == uwgc_pkg::VERDICT_TRUE);
		result_n.is_emoji = (emoji_n == uwgc_pkg::VERDICT_TRUE);

		if (item_s1.final_byte) begin
			pend_n  = 2'd0;
			acc_n   = '0;
			wide_n  = uwgc_pkg::VERDICT_UNDECIDED;
			emoji_n = uwgc_pkg::VERDICT_UNDECIDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			acc_q   <= '0;
			wide_q  <= uwgc_pkg::VERDICT_UNDECIDED;
			emoji_q <= uwgc_pkg::VERDICT_UNDECIDED;
		end else if (adv_s1) begin
			pend_q  <= pend_n;
			acc_q   <= acc_n;
			wide_q  <= wide_n;
			emoji_q <= emoji_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.final_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.final_byte) begin
			result_q <= result_n;
		end
	end

	`UWGC_ASSERT_SAME(a_final_blocks_input,
		byte_valid_s1 && item_s1.final_byte && result_valid_q && !result_ready,
		!byte_ready, "final byte stalled behind a held result but input still ready")

	`UWGC_ASSERT_NEXT(a_final_restarts,
		adv_s1 && item_s1.final_byte,
		pend_q == 2'd0 && wide_q == uwgc_pkg::VERDICT_UNDECIDED &&
			emoji_q == uwgc_pkg::VERDICT_UNDECIDED,
		"decode state not back at start after a final byte")

	`UWGC_ASSERT_ALWAYS(a_emoji_is_wide,
		!result_valid_q || !result_q.is_emoji || result_q.is_wide,
		"result flags emoji without wide")

endmodule

`default_nettype wire

// File: tb/sv/utf8_wide_glyph_classifier_top_test.sv
// Self-checking testbench for the UTF-8 wide glyph classifier top level.
// Depends on uwgc_pkg and utf8_wide_glyph_classifier_top; predicts each
// verdict pair in SystemVerilog and checks every result transfer against it.
`timescale 1ns / 1ps

module utf8_wide_glyph_classifier_top_test;
	import uwgc_pkg::*;

	localparam int RANDOM_BYTES = 1700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AFTER = 30;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		byte_item_t  item;
		int unsigned gap;
	} byte_slot_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         byte_valid = 1'b0;
	logic         byte_ready;
	byte_item_t   byte_item = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result_item;

	byte_slot_t   byte_queue[$];
	logic [7:0]   string_bytes[$];
	result_item_t glyph_verdicts_q[$];

	// Decoder state of the predictor.
	logic [1:0]   cont_left = '0;
	code_point_t  cp_accum = '0;
	verdict_t     wide_state = VERDICT_UNDECIDED;
	verdict_t     emoji_state = VERDICT_UNDECIDED;

	bit           byte_fire = 1'b0;
	bit           result_fire = 1'b0;
	int           cycle_count = 0;
	int           mismatch_count = 0;
	int           verdicts_checked = 0;
	int           bytes_queued = 0;
	int           strings_queued = 0;
	int           malformed_count = 0;
	int unsigned  send_gap_max = 12;

	byte_slot_t   staged_slot;
	bit           staged = 1'b0;
	int unsigned  stage_wait = 0;

	int unsigned  recv_wait = 0;
	int unsigned  recv_gap_max = 12;
	int unsigned  hold_left = 0;
	int           results_taken = 0;

	utf8_wide_glyph_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	always #10 clk = ~clk;

	task automatic abandon_sequence();
		if (wide_state == VERDICT_UNDECIDED) begin
			wide_state = VERDICT_FALSE;
		end
		if (emoji_state == VERDICT_UNDECIDED) begin
			emoji_state = VERDICT_FALSE;
		end
		cont_left = 2'd0;
		cp_accum = '0;
	endtask

	task automatic predict_glyph_byte(input byte_item_t it);
		logic [7:0]   b;
		bit           emo;
		bit           wide;
		result_item_t verdict;
		b = it.text_byte;
		// Once both verdicts are settled the rest of the string is ignored.
		if (wide_state == VERDICT_UNDECIDED || emoji_state == VERDICT_UNDECIDED) begin
			if (cont_left != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					abandon_sequence();
				end else begin
					cp_accum = {cp_accum[CP_W-7:0], b[5:0]};
					cont_left = cont_left - 2'd1;
					if (cont_left == 2'd0) begin
						emo = (cp_accum == CP_VS16) || (cp_accum >= CP_EMOJI_LO);
						wide = emo
							|| (cp_accum >= CP_CJK_LO && cp_accum <= CP_CJK_HI)
							|| (cp_accum >= CP_HANGUL_LO && cp_accum <= CP_HANGUL_HI)
							|| (cp_accum >= CP_FULL_LO && cp_accum <= CP_FULL_HI);
						if (emo && emoji_state == VERDICT_UNDECIDED) begin
							emoji_state = VERDICT_TRUE;
						end
						if (wide && wide_state == VERDICT_UNDECIDED) begin
							wide_state = VERDICT_TRUE;
						end
					end
				end
			end else if (b[7:5] == 3'b110) begin
				cp_accum = code_point_t'(b[4:0]);
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_accum = code_point_t'(b[3:0]);
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_accum = code_point_t'(b[2:0]);
				cont_left = 2'd3;
			end else if (b[7]) begin
				abandon_sequence();
			end
		end
		if (it.final_byte) begin
			if (cont_left != 2'd0) begin
				abandon_sequence();
			end
			verdict.is_wide = (wide_state == VERDICT_TRUE);
			verdict.is_emoji = (emoji_state == VERDICT_TRUE);
			glyph_verdicts_q.push_back(verdict);
			cont_left = 2'd0;
			cp_accum = '0;
			wide_state = VERDICT_UNDECIDED;
			emoji_state = VERDICT_UNDECIDED;
		end
	endtask

	function automatic int utf8_length(input code_point_t cp);
		// A zero code point is sent overlong so that no zero byte appears.
		if (cp < 21'h80 && cp != '0) begin
			return 1;
		end else if (cp < 21'h800) begin
			return 2;
		end else if (cp < 21'h10000) begin
			return 3;
		end
		return 4;
	endfunction

	task automatic encode_code_point(input code_point_t cp, input int nbytes);
		case (nbytes)
			1: begin
				string_bytes.push_back({1'b0, cp[6:0]});
			end
			2: begin
				string_bytes.push_back({3'b110, cp[10:6]});
				string_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				string_bytes.push_back({4'b1110, cp[15:12]});
				string_bytes.push_back({2'b10, cp[11:6]});
				string_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				string_bytes.push_back({5'b11110, cp[20:18]});
				string_bytes.push_back({2'b10, cp[17:12]});
				string_bytes.push_back({2'b10, cp[11:6]});
				string_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	function automatic code_point_t range_edge();
		code_point_t base;
		case ($urandom_range(0, 7))
			0: base = CP_VS16;
			1: base = CP_CJK_LO;
			2: base = CP_CJK_HI;
			3: base = CP_HANGUL_LO;
			4: base = CP_HANGUL_HI;
			5: base = CP_FULL_LO;
			6: base = CP_FULL_HI;
			default: base = CP_EMOJI_LO;
		endcase
		return code_point_t'(base + $urandom_range(0, 2) - 1);
	endfunction

	task automatic add_random_glyph();
		code_point_t cp;
		int          len;
		case ($urandom_range(0, 9))
			0, 1: cp = code_point_t'($urandom_range(1, 127));
			2: cp = code_point_t'($urandom_range(12'h080, 12'h7FF));
			3, 4: cp = range_edge();
			5: cp = code_point_t'($urandom_range(16'h0800, 16'hFFFF));
			6: cp = code_point_t'($urandom_range(CP_CJK_LO, CP_CJK_HI));
			7: cp = code_point_t'($urandom_range(17'h10000, 21'h1FFFFF));
			8: cp = CP_VS16;
			default: cp = code_point_t'($urandom);
		endcase
		len = utf8_length(cp);
		if ($urandom_range(0, 7) == 0) begin
			len = $urandom_range(len, 4);
		end
		encode_code_point(cp, len);
	endtask

	// Moves the staged string onto the byte queue, final flag on its last byte.
	task automatic flush_string();
		byte_slot_t slot;
		for (int i = 0; i < string_bytes.size(); i++) begin
			slot.item.text_byte = string_bytes[i];
			slot.item.final_byte = (i == string_bytes.size() - 1);
			slot.gap = $urandom_range(0, send_gap_max);
			byte_queue.push_back(slot);
		end
		bytes_queued += string_bytes.size();
		strings_queued++;
		string_bytes.delete();
	endtask

	// Sender: a byte offered stays put until its transfer.
	always @(negedge clk) begin
		bit drive_valid;
		drive_valid = byte_valid && !byte_fire;
		if (arst_n && !drive_valid) begin
			if (!staged && byte_queue.size() > 0) begin
				staged_slot = byte_queue.pop_front();
				stage_wait = staged_slot.gap;
				staged = 1'b1;
			end
			if (staged && stage_wait == 0) begin
				byte_item <= staged_slot.item;
				drive_valid = 1'b1;
				staged = 1'b0;
			end else if (staged) begin
				stage_wait--;
			end
		end
		byte_valid <= drive_valid;
	end

	// Receiver: random back-pressure plus one long hold-off.
	always @(negedge clk) begin
		if (result_fire) begin
			results_taken++;
			if (results_taken % 50 == 0) begin
				recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
			end
			if (results_taken == HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
			end
			recv_wait = $urandom_range(0, recv_gap_max);
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (recv_wait > 0) begin
			recv_wait--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Monitor: predicts on byte transfers and checks result transfers.
	always @(posedge clk) begin
		result_item_t want;
		byte_fire <= byte_valid && byte_ready;
		result_fire <= result_valid && result_ready;
		if (arst_n) begin
			cycle_count++;
			if (byte_valid && byte_ready) begin
				predict_glyph_byte(byte_item);
			end
			if (result_valid && result_ready) begin
				if (glyph_verdicts_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got is_wide %0b is_emoji %0b",
						$time, result_item.is_wide, result_item.is_emoji);
					mismatch_count++;
				end else begin
					want = glyph_verdicts_q.pop_front();
					verdicts_checked++;
					if (result_item.is_wide !== want.is_wide) begin
						$display("%0t: is_wide expected %0b, got %0b",
							$time, want.is_wide, result_item.is_wide);
						mismatch_count++;
					end
					if (result_item.is_emoji !== want.is_emoji) begin
						$display("%0t: is_emoji expected %0b, got %0b",
							$time, want.is_emoji, result_item.is_emoji);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("utf8_wide_glyph_classifier_top_test NOT OK");
		$finish;
	end

	initial begin
		int kind;
		int n;
		int directed_bytes;

		// Directed strings: plain ASCII, range bounds, emoji, malformed input.
		encode_code_point(21'h41, 1);
		flush_string();
		string_bytes.push_back(8'h01);
		string_bytes.push_back(8'h7F);
		flush_string();
		encode_code_point(CP_VS16, 3);
		flush_string();
		encode_code_point(CP_EMOJI_LO, 4);
		flush_string();
		encode_code_point(CP_CJK_LO, 3);
		flush_string();
		encode_code_point(CP_HANGUL_HI, 3);
		flush_string();
		encode_code_point(CP_FULL_HI, 3);
		flush_string();
		string_bytes.push_back(8'hFF);
		flush_string();
		string_bytes.push_back(8'h80);
		flush_string();
		// A lead byte on its own is a truncated sequence.
		string_bytes.push_back(8'hE4);
		flush_string();
		string_bytes.push_back(8'hE4);
		string_bytes.push_back(8'h41);
		flush_string();
		directed_bytes = bytes_queued;

		while (bytes_queued < directed_bytes + RANDOM_BYTES) begin
			if (strings_queued % 40 == 0) begin
				send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
			end
			kind = $urandom_range(0, 19);
			if (kind < 3) begin
				n = $urandom_range(1, 6);
				repeat (n) string_bytes.push_back(8'($urandom_range(1, 255)));
				malformed_count++;
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) add_random_glyph();
				if (kind < 6) begin
					// Break the string: cut its tail or overwrite one byte.
					if ($urandom_range(0, 1) == 0 && string_bytes.size() > 1) begin
						n = $urandom_range(1, string_bytes.size() - 1);
						repeat (n) void'(string_bytes.pop_back());
					end else begin
						n = $urandom_range(0, string_bytes.size() - 1);
						string_bytes[n] = 8'($urandom_range(1, 255));
					end
					malformed_count++;
				end
			end
			flush_string();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || staged || byte_valid) @(posedge clk);
		while (glyph_verdicts_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d glyph strings, %0d of them malformed or noise.",
			bytes_queued, strings_queued, malformed_count);
		$display("Checked %0d verdict pairs with random stalls and one %0d-cycle hold-off.",
			verdicts_checked, HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("utf8_wide_glyph_classifier_top_test OK");
		end else begin
			$display("utf8_wide_glyph_classifier_top_test NOT OK");
		end
		$finish;
	end

endmodule

// File: utf8_wide_glyph_classifier_top.f
+incdir+sv
sv/uwgc_pkg.sv
sv/utf8_wide_glyph_classifier_top.sv
tb/sv/utf8_wide_glyph_classifier_top_test.sv
